[hw/rtl/ptw_pkg.sv]
// shared types, codes and parameter defaults for the periodic timing wheel
package ptw_pkg;

    // parameter defaults
    localparam int WHEEL_SLOTS_DEF = 16;
    localparam int MAX_TIMERS_DEF  = 16;
    localparam int PERIOD_BITS_DEF = 16;

    // fixed field widths of the stream ports
    localparam int ID_FIELD_W     = 4;
    localparam int PERIOD_FIELD_W = 16;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 8;

    // input mode codes carried on tuser
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_FLUSH,
        ST_RESP
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/ptw_div.sv]
// constant divider of a period by the wheel size, one quotient byte per cycle
module ptw_div #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF,
    parameter int PERIOD_BITS = ptw_pkg::PERIOD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [PERIOD_BITS-1:0]           i_dividend,
    output logic [PERIOD_BITS-1:0]           o_quo,
    output logic [$clog2(WHEEL_SLOTS)-1:0]   o_rem,
    output ptw_pkg::t_div_stat               o_stat
);
    import ptw_pkg::*;

    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int DIG_W  = 8;
    localparam int N_DIG  = (PERIOD_BITS + DIG_W - 1) / DIG_W;
    localparam int PAD_W  = N_DIG * DIG_W;
    localparam int CNT_W  = $clog2(N_DIG + 1);
    // partial dividend: running remainder above the next byte
    localparam int T_W    = SLOT_W + DIG_W;
    // scaled reciprocal, exact for every partial dividend below WHEEL_SLOTS * 256
    localparam int SHIFT  = T_W + SLOT_W;
    localparam int RECIP  = ((1 << SHIFT) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;
    localparam int PROD_W = 2 * T_W + 1;

    logic [PAD_W-1:0]       r_dvd;
    logic [SLOT_W-1:0]      r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [T_W-1:0]         w_part;
    logic [PROD_W-1:0]      w_prod;
    logic [DIG_W-1:0]       w_qdig;
    logic [T_W-1:0]         w_back;
    logic [T_W-1:0]         w_left;

    // quotient digit by reciprocal multiplication, remainder by back-multiplication
    assign w_part = {r_rem, r_dvd[PAD_W-1 -: DIG_W]};
    assign w_prod = PROD_W'(w_part) * PROD_W'(RECIP);
    assign w_qdig = w_prod[SHIFT +: DIG_W];
    assign w_back = T_W'(w_qdig) * T_W'(WHEEL_SLOTS);
    assign w_left = w_part - w_back;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_DIG);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend register collects the quotient bytes from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= PAD_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= (r_dvd << DIG_W) | PAD_W'(w_qdig);
            r_rem <= w_left[SLOT_W-1:0];
        end
    end

    assign o_quo       = r_dvd[PERIOD_BITS-1:0];
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[hw/rtl/ptw_entry_ram.sv]
// timer entry memory, one write and one registered read port
module ptw_entry_ram #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = ptw_pkg::MAX_TIMERS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    import ptw_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/periodic_timing_wheel.sv]
// Periodic hashed timing wheel: entry memory scan, divider for add, result register.
// Tick: the scan reads one entry per cycle through the entry memory read port,
//   holding while an expiry waits on a stalled output.
// Add goes through the byte-wise divider; delete is answered without it.
// One item is worked on at a time; the next is taken once the last result is queued.
// Synchronous active-low reset clears the armed bits, the current slot and control;
//   the entry memory is not cleared and its contents are used only for armed timers.
module periodic_timing_wheel #(
    parameter int WHEEL_SLOTS = ptw_pkg::WHEEL_SLOTS_DEF,
    parameter int MAX_TIMERS  = ptw_pkg::MAX_TIMERS_DEF,
    parameter int PERIOD_BITS = ptw_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // timer_id [3:0], period [19:4], zero pad [23:20]
    input  logic [ptw_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // mode [1:0]
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // expired_id [3:0], expired [4], status [5], zero pad [7:6]
    output logic [ptw_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready
);
    import ptw_pkg::*;

    localparam int SLOT_W = $clog2(WHEEL_SLOTS);
    localparam int ID_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int PB     = PERIOD_BITS;
    localparam int ENT_W  = 2 * PB + 2 * SLOT_W;
    // entry layout: rounds, slot, slot offset remainder, rounds reload
    localparam int RND_LO = 0;
    localparam int SLT_LO = PB;
    localparam int REM_LO = PB + SLOT_W;
    localparam int QUO_LO = PB + 2 * SLOT_W;

    // state
    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_cur;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [ID_W-1:0]       r_idx;
    logic [ID_W-1:0]       r_id;
    logic                  r_status;
    logic                  r_pend_v;
    logic [ID_FIELD_W-1:0] r_pend_id;
    logic                  r_out_v;
    logic [ID_FIELD_W-1:0] r_out_id;
    logic                  r_out_exp;
    logic                  r_out_st;
    logic                  r_out_last;

    // input fields
    logic [1:0]            w_mode;
    logic [7:0]            w_tid8;
    logic [ID_W-1:0]       w_id;
    logic                  w_id_ok;
    logic [31:0]           w_per32;
    logic [PB-1:0]         w_per;
    logic [PB-1:0]         w_dvd;
    logic                  w_in_acc;
    logic                  w_out_free;

    // memory and divider
    logic                  w_we;
    logic [ID_W-1:0]       w_waddr;
    logic [ENT_W-1:0]      w_wdata;
    logic [ID_W-1:0]       w_raddr;
    logic [ENT_W-1:0]      w_rd;
    logic                  w_div_start;
    logic [PB-1:0]         w_quo;
    logic [SLOT_W-1:0]     w_rem;
    t_div_stat             w_div_stat;

    // scan
    logic [PB-1:0]         w_rd_rnd;
    logic [SLOT_W-1:0]     w_rd_slot;
    logic [SLOT_W-1:0]     w_rd_rem;
    logic [PB-1:0]         w_rd_quo;
    logic                  w_hit;
    logic                  w_exp;
    logic                  w_stall;
    logic                  w_scan_end;
    logic [7:0]            w_idx8;
    logic [SLOT_W-1:0]     w_rem_sel;
    logic [SLOT_W:0]       w_sum;
    logic [SLOT_W-1:0]     w_new_slot;
    logic [SLOT_W:0]       w_cur_inc;
    logic [SLOT_W-1:0]     w_cur_next;

    // output load
    logic                  w_out_load;
    logic [ID_FIELD_W-1:0] w_o_id;
    logic                  w_o_exp;
    logic                  w_o_st;
    logic                  w_o_last;

    // field extraction
    assign w_mode   = i_s_tuser;
    assign w_tid8   = {4'b0, i_s_tdata[ID_FIELD_W-1:0]};
    assign w_id     = w_tid8[ID_W-1:0];
    assign w_id_ok  = w_tid8 < 8'(MAX_TIMERS);
    assign w_per32  = {16'b0, i_s_tdata[ID_FIELD_W +: PERIOD_FIELD_W]};
    assign w_per    = w_per32[PB-1:0];
    // a zero period counts as one tick
    assign w_dvd    = (w_per == '0) ? '0 : w_per - 1'b1;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_v || i_m_tready;

    // entry read data
    assign w_rd_rnd   = w_rd[RND_LO +: PB];
    assign w_rd_slot  = w_rd[SLT_LO +: SLOT_W];
    assign w_rd_rem   = w_rd[REM_LO +: SLOT_W];
    assign w_rd_quo   = w_rd[QUO_LO +: PB];

    assign w_hit      = r_valid[r_idx] && (w_rd_slot == r_cur);
    assign w_exp      = w_hit && (w_rd_rnd == '0);
    assign w_stall    = w_exp && r_pend_v && !w_out_free;
    assign w_scan_end = (r_idx == ID_W'(MAX_TIMERS - 1));
    assign w_idx8     = 8'(r_idx);

    // slot of a freshly armed timer: current + remainder + 1, folded once
    assign w_rem_sel  = (r_state == ST_DIV) ? w_rem : w_rd_rem;
    assign w_sum      = {1'b0, r_cur} + {1'b0, w_rem_sel} + (SLOT_W+1)'(1);
    assign w_new_slot = (w_sum >= (SLOT_W+1)'(WHEEL_SLOTS))
                      ? SLOT_W'(w_sum - (SLOT_W+1)'(WHEEL_SLOTS)) : w_sum[SLOT_W-1:0];

    // wheel advance
    assign w_cur_inc  = {1'b0, r_cur} + (SLOT_W+1)'(1);
    assign w_cur_next = (w_cur_inc == (SLOT_W+1)'(WHEEL_SLOTS)) ? '0 : w_cur_inc[SLOT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_mode == MODE_TICK) begin
                        n_state = ST_SCAN;
                    end else if (w_mode == MODE_ADD && w_id_ok) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) n_state = ST_RESP;
            end
            ST_SCAN: begin
                if (!w_stall && w_scan_end) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            ST_RESP: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {w_rd_quo, w_rd_rem, w_rd_slot, w_rd_rnd - 1'b1};
        w_raddr     = '0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_o_id      = '0;
        w_o_exp     = 1'b0;
        w_o_st      = 1'b0;
        w_o_last    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                w_div_start = w_in_acc && (w_mode == MODE_ADD) && w_id_ok;
            end
            ST_DIV: begin
                w_we    = w_div_stat.done;
                w_waddr = r_id;
                w_wdata = {w_quo, w_rem, w_new_slot, w_quo};
            end
            ST_SCAN: begin
                w_raddr = (w_stall || w_scan_end) ? r_idx : r_idx + 1'b1;
                w_we    = w_hit && !w_stall;
                if (w_exp) begin
                    w_wdata = {w_rd_quo, w_rd_rem, w_new_slot, w_rd_quo};
                end
                // an earlier expiry is known not to be the last one
                w_out_load = w_exp && !w_stall && r_pend_v;
                w_o_id     = r_pend_id;
                w_o_exp    = 1'b1;
                w_o_last   = 1'b0;
            end
            ST_FLUSH: begin
                w_out_load = w_out_free;
                w_o_id     = r_pend_v ? r_pend_id : '0;
                w_o_exp    = r_pend_v;
            end
            ST_RESP: begin
                w_out_load = w_out_free;
                w_o_st     = r_status;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    // control and wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= '0;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (w_mode == MODE_TICK) begin
                    r_cur <= w_cur_next;
                end else if (w_mode == MODE_DEL && w_id_ok && r_valid[w_id]) begin
                    r_valid[w_id] <= 1'b0;
                end
            end
            if (r_state == ST_DIV && w_div_stat.done) begin
                r_valid[r_id] <= 1'b1;
            end
            if (r_state == ST_SCAN && w_exp && !w_stall) begin
                r_pend_v <= 1'b1;
            end
            if (r_state == ST_FLUSH && w_out_free) begin
                r_pend_v <= 1'b0;
            end
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // item payload, scan index and result register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_idx    <= '0;
            r_id     <= w_id;
            r_status <= (w_mode == MODE_DEL) && !(w_id_ok && r_valid[w_id]);
        end else if (r_state == ST_SCAN && !w_stall && !w_scan_end) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == ST_SCAN && w_exp && !w_stall) begin
            r_pend_id <= w_idx8[ID_FIELD_W-1:0];
        end
        if (w_out_load) begin
            r_out_id   <= w_o_id;
            r_out_exp  <= w_o_exp;
            r_out_st   <= w_o_st;
            r_out_last <= w_o_last;
        end
    end

    ptw_entry_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (MAX_TIMERS),
        .ADDR_W (ID_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    ptw_div #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .o_quo      (w_quo),
        .o_rem      (w_rem),
        .o_stat     (w_div_stat)
    );

    // result port
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out_st, r_out_exp, r_out_id};
    assign o_m_tlast  = r_out_last;

endmodule

[hw/rtl/ptw_checker.sv]
// port-level checks of the timing wheel result stream, bound to the top level
module ptw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // a result without an expiry carries no id
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[4] |-> o_m_tdata[3:0] == 4'd0)
        else $error("expired_id set without expired");

    // a result without an expiry is always the only one of its item
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[4] |-> o_m_tlast)
        else $error("non-expiry result not marked last");

    // an error status never comes with an expiry and leaves the pad bits zero
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5] |-> !o_m_tdata[4] && o_m_tdata[7:6] == 2'b00)
        else $error("status set on an expiry result");

endmodule

bind periodic_timing_wheel ptw_checker u_ptw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
